// ===== hw/rtl/binary32_multiplier_core_defines.svh =====
// Assertion macros used by the b32m_checker module.
`ifndef BINARY32_MULTIPLIER_CORE_DEFINES_SVH
`define BINARY32_MULTIPLIER_CORE_DEFINES_SVH

// Asserts that an antecedent implies a consequent in the same cycle.
`define B32M_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Asserts that an antecedent implies a consequent in the following cycle.
`define B32M_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/b32m_pkg.sv =====
package b32m_pkg;

   localparam int unsigned WordWidth = 32;
   localparam int unsigned ExpWidth  = 8;
   localparam int unsigned FracWidth = 23;
   localparam int unsigned SigWidth  = FracWidth + 1;
   localparam int unsigned ProdWidth = 2 * SigWidth;

   localparam logic [ExpWidth-1:0]  ExpAllOnes = 8'hFF;
   localparam logic [9:0]           ExpBias    = 10'd127;
   localparam logic [WordWidth-1:0] CanonNan   = 32'h7FC0_0000;
   localparam logic [WordWidth-1:0] InfBits    = 32'h7F80_0000;

   // Operand classification and preprocessed fields for the second stage.
   typedef struct packed {
      logic                 special;
      logic [WordWidth-1:0] special_word;
      logic                 sign;
      logic signed [9:0]    exp_sum;
      logic [ProdWidth-1:0] prod;
   } mul_stage_type;

endpackage

// ===== hw/rtl/b32m_round.sv =====
module b32m_round (
   input  b32m_pkg::mul_stage_type stage,
   output logic [b32m_pkg::WordWidth-1:0] product
);

   localparam int unsigned PW = b32m_pkg::ProdWidth;

   logic [5:0]         lead;
   logic [PW-1:0]      norm;
   logic signed [10:0] e;
   logic [PW-1:0]      den;
   logic [11:0]        sh;
   logic [24:0]        m;
   logic [31:0]        packed_word;

   always_comb begin
      lead = '0;
      for (int i = 0; i < PW; i++) begin
         if (stage.prod[i]) begin
            lead = 6'(i);
         end
      end
      if (lead == 6'd47) begin
         norm = stage.prod >> 1;
         e    = 11'(stage.exp_sum) + 11'sd1;
      end else begin
         norm = stage.prod << (6'd46 - lead);
         e    = 11'(stage.exp_sum) - 11'(signed'({5'd0, 6'd46 - lead}));
      end
      den = norm;
      sh  = '0;
      if (e <= 11'sd0) begin
         sh = 12'(signed'(11'sd1 - e));
         if (sh >= 12'd48) begin
            den = '0;
         end else begin
            den = norm >> sh[5:0];
         end
      end
      m = 25'(den[PW-1:23]) + 25'(den[22]);
      if (e <= 11'sd0) begin
         packed_word = {stage.sign, 31'(m)};
      end else begin
         packed_word = {stage.sign, 31'({8'(e - 11'sd1), 23'd0} + 31'(m))};
      end
      if (stage.special) begin
         product = stage.special_word;
      end else if (e >= 11'sd255) begin
         product = {stage.sign, b32m_pkg::InfBits[30:0]};
      end else begin
         product = packed_word;
      end
   end

endmodule

// ===== hw/rtl/binary32_multiplier_core.sv =====
// The significand product is registered in stage_ff, the rounded result in out_ff.
// Throughput: one transaction per cycle unless a held result waits on rsp_ready.
// A valid result register holds while rsp_ready is low and the pipe stalls behind it.
// Reset clears both valid flags; the data registers are not reset.
module binary32_multiplier_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_op_a,
   input  logic [31:0] req_op_b,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_product
);

   b32m_pkg::mul_stage_type stage_ff, stage_in;
   logic                    stage_valid_ff;
   logic                    out_valid_ff;
   logic [31:0]             out_ff, out_in;
   logic                    advance;
   logic [7:0]  ea, eb;
   logic [22:0] fa, fb;
   logic nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, sgn;

   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = advance;

   always_comb begin
      ea = req_op_a[30:23];
      eb = req_op_b[30:23];
      fa = req_op_a[22:0];
      fb = req_op_b[22:0];
      sgn = req_op_a[31] ^ req_op_b[31];
      nan_a  = (ea == b32m_pkg::ExpAllOnes) && (fa != '0);
      nan_b  = (eb == b32m_pkg::ExpAllOnes) && (fb != '0);
      inf_a  = (ea == b32m_pkg::ExpAllOnes) && (fa == '0);
      inf_b  = (eb == b32m_pkg::ExpAllOnes) && (fb == '0);
      zero_a = (ea == '0) && (fa == '0);
      zero_b = (eb == '0) && (fb == '0);
      stage_in.sign = sgn;
      stage_in.special = nan_a || nan_b || inf_a || inf_b || zero_a || zero_b;
      if (nan_a || nan_b || (inf_a && zero_b) || (zero_a && inf_b)) begin
         stage_in.special_word = b32m_pkg::CanonNan;
      end else if (inf_a || inf_b) begin
         stage_in.special_word = {sgn, b32m_pkg::InfBits[30:0]};
      end else begin
         stage_in.special_word = {sgn, 31'd0};
      end
      stage_in.exp_sum = signed'(10'((ea != '0) ? ea : 8'd1) + 10'((eb != '0) ? eb : 8'd1)
                                 - b32m_pkg::ExpBias);
      stage_in.prod = 48'({(ea != '0), fa}) * 48'({(eb != '0), fb});
   end

   b32m_round u_round (
      .stage   (stage_ff),
      .product (out_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else if (advance) begin
         stage_valid_ff <= req_valid;
         out_valid_ff   <= stage_valid_ff;
      end
      if (advance) begin
         stage_ff <= stage_in;
         out_ff   <= out_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_product = out_ff;

endmodule

// ===== hw/rtl/b32m_checker.sv =====
`include "binary32_multiplier_core_defines.svh"

module b32m_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_product
);

   `B32M_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_product), "stalled result changed")
   `B32M_ASSERT_IMP(a_ready_when_empty, clock, reset, !rsp_valid, req_ready, "not ready with empty output")
   `B32M_ASSERT_IMP(a_stall_blocks, clock, reset, rsp_valid && !rsp_ready, !req_ready, "input taken during stall")
   `B32M_ASSERT_IMP(a_nan_canonical, clock, reset, rsp_valid && rsp_product[30:23] == 8'hFF && rsp_product[22:0] != 23'd0, rsp_product == 32'h7FC0_0000, "non-canonical NaN")

endmodule

bind binary32_multiplier_core b32m_checker u_b32m_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_product (rsp_product)
);

// ===== verif/binary32_multiplier_checker.sv =====
`timescale 1ns / 100ps

module binary32_multiplier_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_op_a,
   input  logic [31:0] req_op_b,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_product,
   output int          fail_count,
   output int          pending
);

   logic [31:0] expected_products[$];

   initial fail_count = 0;
   initial pending = 0;

   function automatic logic [31:0] predict_product(input logic [31:0] a, input logic [31:0] b);
      logic        sign;
      logic [7:0]  ea;
      logic [7:0]  eb;
      logic [22:0] fa;
      logic [22:0] fb;
      logic [47:0] p;
      logic [31:0] m;
      logic [31:0] ebits;
      int          e;
      int          lead;
      int          sh;
      sign = a[31] ^ b[31];
      ea = a[30:23];
      eb = b[30:23];
      fa = a[22:0];
      fb = b[22:0];
      if ((ea == b32m_pkg::ExpAllOnes && fa != 0) || (eb == b32m_pkg::ExpAllOnes && fb != 0))
         return b32m_pkg::CanonNan;
      if ((ea == b32m_pkg::ExpAllOnes && eb == 0 && fb == 0)
          || (eb == b32m_pkg::ExpAllOnes && ea == 0 && fa == 0))
         return b32m_pkg::CanonNan;
      if (ea == b32m_pkg::ExpAllOnes || eb == b32m_pkg::ExpAllOnes)
         return {sign, b32m_pkg::InfBits[30:0]};
      if ((ea == 0 && fa == 0) || (eb == 0 && fb == 0))
         return {sign, 31'd0};
      p = {24'd0, (ea != 0), fa} * {24'd0, (eb != 0), fb};
      e = ((ea != 0) ? int'(ea) : 1) + ((eb != 0) ? int'(eb) : 1) - 127;
      lead = 47;
      while (lead > 0 && !p[lead])
         lead--;
      if (lead > 46) begin
         p = p >> 1;
         e = e + 1;
      end else begin
         p = p << (46 - lead);
         e = e - (46 - lead);
      end
      if (e >= 255)
         return {sign, b32m_pkg::InfBits[30:0]};
      if (e <= 0) begin
         sh = 1 - e;
         if (sh >= 48)
            p = '0;
         else
            p = p >> sh;
         e = 0;
      end
      m = {8'd0, p[46:23]} + {31'd0, p[22]};
      if (e == 0)
         return {sign, 31'd0} | m;
      ebits = (32'(e - 1)) << 23;
      return {sign, 31'd0} | (ebits + m);
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t: %s", $realtime, what);
      fail_count++;
   endtask

   always @(posedge clock) begin
      logic [31:0] want;
      if (!reset) begin
         // The oldest expectation is retired before the new transaction is queued.
         if (rsp_valid && rsp_ready) begin
            if (expected_products.size() == 0) begin
               report_mismatch($sformatf("unexpected product %h", rsp_product));
            end else begin
               want = expected_products.pop_front();
               if (rsp_product !== want)
                  report_mismatch($sformatf("product %h, wanted %h", rsp_product, want));
            end
         end
         if (req_valid && req_ready)
            expected_products.push_back(predict_product(req_op_a, req_op_b));
      end
      pending = expected_products.size();
   end

endmodule

// ===== verif/binary32_multiplier_core_tb.sv =====
`timescale 1ns / 100ps

module binary32_multiplier_core_tb;

   localparam int StallLimit = 2000;
   localparam int RandomItems = 500;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_op_a = '0;
   logic [31:0] req_op_b = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_product;
   int          fail_count;
   int          pending;
   int          idle_cycles = 0;
   logic        quiet_mode = 1'b0;

   always #5 clock = ~clock;

   binary32_multiplier_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_op_a(req_op_a), .req_op_b(req_op_b),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_product(rsp_product)
   );

   binary32_multiplier_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_op_a(req_op_a), .req_op_b(req_op_b),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_product(rsp_product),
      .fail_count(fail_count), .pending(pending)
   );

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Result side: a random hold-off before each transaction, none while quiet.
   initial begin
      int n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         n = quiet_mode ? 0 : $urandom_range(12);
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   function automatic logic [31:0] random_operand();
      logic [7:0]  ex;
      logic [22:0] fr;
      case ($urandom_range(9))
         0: ex = 8'h00;
         1: ex = 8'hFF;
         2: ex = 8'h01;
         3: ex = 8'hFE;
         4: ex = 8'($urandom_range(40));
         5: ex = 8'($urandom_range(255, 215));
         6, 7: ex = 8'($urandom_range(150, 100));
         default: ex = 8'($urandom);
      endcase
      case ($urandom_range(5))
         0: fr = '0;
         1: fr = '1;
         2: fr = 23'(1) << $urandom_range(22);
         default: fr = 23'($urandom);
      endcase
      return {1'($urandom), ex, fr};
   endfunction

   // Drives one transaction after the given gap and returns once it is accepted.
   task automatic send_operands(input logic [31:0] a, input logic [31:0] b, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op_a  <= a;
      req_op_b  <= b;
      do @(posedge clock); while (!req_ready);
   endtask

   logic [31:0] directed_a[$] = '{
      32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7F80_0000,
      32'h7FC0_0001, 32'h3F80_0000, 32'hFFFF_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF,
      32'h0000_0001, 32'h0000_0001, 32'h0080_0000, 32'h3FC0_0000, 32'h3F80_0001,
      32'h007F_FFFF, 32'h0000_0003, 32'hC000_0000, 32'h3F7F_FFFF, 32'h0040_0000
   };
   logic [31:0] directed_b[$] = '{
      32'h0000_0000, 32'h3F80_0000, 32'h0000_0000, 32'hBF80_0000, 32'h8000_0001,
      32'h3F80_0000, 32'h7F81_0000, 32'h0000_0000, 32'h7F7F_FFFF, 32'h3F80_0001,
      32'h3F00_0000, 32'h3EFF_FFFF, 32'h3F00_0000, 32'h3FC0_0000, 32'h3F80_0001,
      32'h3F80_0000, 32'h3E80_0000, 32'h4040_0000, 32'h3F80_0001, 32'h0040_0000
   };

   initial begin
      int burst;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < directed_a.size(); i++)
         send_operands(directed_a[i], directed_b[i], $urandom_range(3));
      for (int i = 0; i < RandomItems; i++) begin
         if (i % 50 == 0) begin
            burst = $urandom_range(2);
            quiet_mode <= (burst == 0);
         end
         if (i == RandomItems / 2) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending != 0) @(posedge clock);
         end
         send_operands(random_operand(), ($urandom_range(9) == 0) ? 32'($urandom)
                       : random_operand(), (burst == 0) ? 0 : $urandom_range(12));
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
